FILE: hdl/nnsa_pkg.sv
// Shared types, constants and helpers for the nearest-neighbour scaling address generator.
package nnsa_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int POS_W      = 12;
  localparam int DIM_W      = 13;
  localparam int OFS_W      = 26;
  localparam int DVD_W      = 2 * POS_W;
  localparam int CNT_W      = $clog2(DVD_W);
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_LEFT   = 3'd0,
    REG_SRC_TOP    = 3'd1,
    REG_SRC_WIDTH  = 3'd2,
    REG_SRC_HEIGHT = 3'd3,
    REG_DST_LEFT   = 3'd4,
    REG_DST_TOP    = 3'd5,
    REG_DST_WIDTH  = 3'd6,
    REG_DST_HEIGHT = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIV_COL_RATIO = 2'd0,
    DIV_ROW_RATIO = 2'd1,
    DIV_COL_POS   = 2'd2,
    DIV_ROW_POS   = 2'd3
  } div_sel_t;

  typedef struct packed {
    logic     step;
    logic     move;
    logic     div_start;
    logic     div_load;
    div_sel_t div_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_status_t;

  // A size register of zero counts as one, and anything above the maximum is clipped.
  function automatic logic [DIM_W-1:0] size_of(input logic [DIM_W-1:0] reg_val);
    if (reg_val == '0) begin
      return DIM_W'(1);
    end else if (int'(reg_val) > MAX_DIM) begin
      return DIM_W'(MAX_DIM);
    end else begin
      return reg_val;
    end
  endfunction

endpackage

FILE: hdl/nnsa_div.sv
// Restoring serial divider, one quotient bit per cycle.
module nnsa_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [nnsa_pkg::DVD_W-1:0] dividend,
  input  logic [nnsa_pkg::DIM_W-1:0] divisor,
  output logic                       done,
  output logic [nnsa_pkg::DVD_W-1:0] quotient,
  output logic [nnsa_pkg::DIM_W-1:0] remainder
);
  import nnsa_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] quo_r;
  logic [DIM_W-1:0] rem_r;
  logic [DIM_W-1:0] dvs_r;
  logic [DIM_W:0]   trial;
  logic [DIM_W:0]   diff;
  logic             fits;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], fits};
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_r)
    else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider finished without running");

endmodule

FILE: hdl/nnsa_dp.sv
// Datapath: configuration registers, scan state, remainder stepping and offset pipeline.
module nnsa_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  nnsa_pkg::cfg_reg_t             cfg_index,
  input  logic [nnsa_pkg::DIM_W-1:0]     cfg_data,
  input  logic                           in_restart,
  input  nnsa_pkg::dp_cmd_t              cmd,
  output nnsa_pkg::dp_status_t           status,
  output logic [nnsa_pkg::OFS_W-1:0]     out_src_offset,
  output logic [nnsa_pkg::OFS_W-1:0]     out_dst_offset,
  output logic                           out_row_end,
  output logic                           out_frame_end
);
  import nnsa_pkg::*;

  logic [POS_W-1:0] src_left_r, src_top_r, dst_left_r, dst_top_r;
  logic [DIM_W-1:0] src_width_r, src_height_r, dst_width_r, dst_height_r;
  logic [DIM_W-1:0] sw, sh, dw, dh;

  // Scan state for the next pixel to be emitted.
  logic [POS_W-1:0] out_row_r, out_col_r, in_row_r, row_rem_r, in_col_r, col_rem_r;
  logic [POS_W-1:0] out_row_nxt, out_col_nxt, in_row_nxt, row_rem_nxt, in_col_nxt, col_rem_nxt;

  // Quotient and remainder of the size ratios.
  logic [DIM_W-1:0] col_q_r, row_q_r;
  logic [POS_W-1:0] col_r_r, row_r_r;

  logic [POS_W-1:0]       mul_a;
  logic [DIM_W-1:0]       mul_b;
  logic [POS_W+DIM_W-1:0] mul_p;
  logic [DIM_W-1:0]       div_dvs;
  logic                   div_done;
  logic [DVD_W-1:0]       div_quo;
  logic [DIM_W-1:0]       div_rem;

  logic             pos_zero;
  logic [POS_W-1:0] cur_row, cur_col, cur_irow, cur_rrem, cur_icol, cur_crem;
  logic             col_last, row_last, row_end, frame_end;
  logic [DIM_W-1:0] col_sum, row_sum, icol_sum, irow_sum;
  logic             col_wrap, row_wrap;
  logic [POS_W-1:0] col_step_rem, row_step_rem;

  logic [DIM_W-1:0] s1_src_base_r, s1_src_add_r, s1_dst_base_r, s1_dst_add_r;
  logic             s1_row_end_r, s1_frame_end_r;
  logic [OFS_W-1:0] s2_src_prod_r, s2_dst_prod_r;
  logic [DIM_W-1:0] s2_src_add_r, s2_dst_add_r;
  logic             s2_row_end_r, s2_frame_end_r;
  logic [OFS_W-1:0] out_src_offset_r, out_dst_offset_r;
  logic             out_row_end_r, out_frame_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_left_r   <= '0;
      src_top_r    <= '0;
      src_width_r  <= DIM_W'(1);
      src_height_r <= DIM_W'(1);
      dst_left_r   <= '0;
      dst_top_r    <= '0;
      dst_width_r  <= DIM_W'(1);
      dst_height_r <= DIM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SRC_LEFT:   src_left_r   <= cfg_data[POS_W-1:0];
        REG_SRC_TOP:    src_top_r    <= cfg_data[POS_W-1:0];
        REG_SRC_WIDTH:  src_width_r  <= cfg_data;
        REG_SRC_HEIGHT: src_height_r <= cfg_data;
        REG_DST_LEFT:   dst_left_r   <= cfg_data[POS_W-1:0];
        REG_DST_TOP:    dst_top_r    <= cfg_data[POS_W-1:0];
        REG_DST_WIDTH:  dst_width_r  <= cfg_data;
        REG_DST_HEIGHT: dst_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sw = size_of(src_width_r);
  assign sh = size_of(src_height_r);
  assign dw = size_of(dst_width_r);
  assign dh = size_of(dst_height_r);

  // Operand selection for the shared divider.
  always_comb begin
    unique case (cmd.div_sel)
      DIV_COL_RATIO: begin
        mul_a   = POS_W'(1);
        mul_b   = sw;
        div_dvs = dw;
      end
      DIV_ROW_RATIO: begin
        mul_a   = POS_W'(1);
        mul_b   = sh;
        div_dvs = dh;
      end
      DIV_COL_POS: begin
        mul_a   = out_col_r;
        mul_b   = sw;
        div_dvs = dw;
      end
      DIV_ROW_POS: begin
        mul_a   = out_row_r;
        mul_b   = sh;
        div_dvs = dh;
      end
      default: begin
        mul_a   = '0;
        mul_b   = sw;
        div_dvs = dw;
      end
    endcase
  end

  assign mul_p = (POS_W+DIM_W)'(mul_a) * (POS_W+DIM_W)'(mul_b);

  nnsa_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (mul_p[DVD_W-1:0]),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign status.div_done = div_done;

  // A restart, or a position left outside a shrunken rectangle, begins at the first pixel.
  assign pos_zero = in_restart || ({1'b0, out_col_r} >= dw) || ({1'b0, out_row_r} >= dh);
  assign cur_row  = pos_zero ? '0 : out_row_r;
  assign cur_col  = pos_zero ? '0 : out_col_r;
  assign cur_irow = pos_zero ? '0 : in_row_r;
  assign cur_rrem = pos_zero ? '0 : row_rem_r;
  assign cur_icol = pos_zero ? '0 : in_col_r;
  assign cur_crem = pos_zero ? '0 : col_rem_r;

  assign col_last  = (({1'b0, cur_col} + DIM_W'(1)) == dw);
  assign row_last  = (({1'b0, cur_row} + DIM_W'(1)) == dh);
  assign row_end   = col_last;
  assign frame_end = col_last && row_last;

  // Both remainders stay below the divisor, so one compare and subtract keeps them in range.
  assign col_sum      = {1'b0, cur_crem} + {1'b0, col_r_r};
  assign col_wrap     = (col_sum >= dw);
  assign col_step_rem = col_wrap ? POS_W'(col_sum - dw) : col_sum[POS_W-1:0];
  assign icol_sum     = {1'b0, cur_icol} + col_q_r + {{(DIM_W-1){1'b0}}, col_wrap};

  assign row_sum      = {1'b0, cur_rrem} + {1'b0, row_r_r};
  assign row_wrap     = (row_sum >= dh);
  assign row_step_rem = row_wrap ? POS_W'(row_sum - dh) : row_sum[POS_W-1:0];
  assign irow_sum     = {1'b0, cur_irow} + row_q_r + {{(DIM_W-1){1'b0}}, row_wrap};

  always_comb begin
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    in_row_nxt  = in_row_r;
    row_rem_nxt = row_rem_r;
    in_col_nxt  = in_col_r;
    col_rem_nxt = col_rem_r;
    if (cmd.step) begin
      if (frame_end) begin
        out_row_nxt = '0;
        in_row_nxt  = '0;
        row_rem_nxt = '0;
        out_col_nxt = '0;
        in_col_nxt  = '0;
        col_rem_nxt = '0;
      end else if (row_end) begin
        out_row_nxt = cur_row + POS_W'(1);
        in_row_nxt  = irow_sum[POS_W-1:0];
        row_rem_nxt = row_step_rem;
        out_col_nxt = '0;
        in_col_nxt  = '0;
        col_rem_nxt = '0;
      end else begin
        out_row_nxt = cur_row;
        in_row_nxt  = cur_irow;
        row_rem_nxt = cur_rrem;
        out_col_nxt = cur_col + POS_W'(1);
        in_col_nxt  = icol_sum[POS_W-1:0];
        col_rem_nxt = col_step_rem;
      end
    end else if (cmd.div_load) begin
      if (cmd.div_sel == DIV_COL_POS) begin
        in_col_nxt  = div_quo[POS_W-1:0];
        col_rem_nxt = div_rem[POS_W-1:0];
      end else if (cmd.div_sel == DIV_ROW_POS) begin
        in_row_nxt  = div_quo[POS_W-1:0];
        row_rem_nxt = div_rem[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_row_r <= '0;
      out_col_r <= '0;
      in_row_r  <= '0;
      row_rem_r <= '0;
      in_col_r  <= '0;
      col_rem_r <= '0;
    end else begin
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
      in_row_r  <= in_row_nxt;
      row_rem_r <= row_rem_nxt;
      in_col_r  <= in_col_nxt;
      col_rem_r <= col_rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load && (cmd.div_sel == DIV_COL_RATIO)) begin
      col_q_r <= div_quo[DIM_W-1:0];
      col_r_r <= div_rem[POS_W-1:0];
    end
    if (cmd.div_load && (cmd.div_sel == DIV_ROW_RATIO)) begin
      row_q_r <= div_quo[DIM_W-1:0];
      row_r_r <= div_rem[POS_W-1:0];
    end
  end

  // Offset pipeline: base sums, then the stride products, then the final add.
  always_ff @(posedge clk) begin
    if (cmd.move) begin
      s1_src_base_r    <= {1'b0, src_top_r} + {1'b0, cur_irow};
      s1_src_add_r     <= {1'b0, src_left_r} + {1'b0, cur_icol};
      s1_dst_base_r    <= {1'b0, dst_top_r} + {1'b0, cur_row};
      s1_dst_add_r     <= {1'b0, dst_left_r} + {1'b0, cur_col};
      s1_row_end_r     <= row_end;
      s1_frame_end_r   <= frame_end;
      s2_src_prod_r    <= OFS_W'(s1_src_base_r) * OFS_W'(sw);
      s2_dst_prod_r    <= OFS_W'(s1_dst_base_r) * OFS_W'(dw);
      s2_src_add_r     <= s1_src_add_r;
      s2_dst_add_r     <= s1_dst_add_r;
      s2_row_end_r     <= s1_row_end_r;
      s2_frame_end_r   <= s1_frame_end_r;
      out_src_offset_r <= s2_src_prod_r + OFS_W'(s2_src_add_r);
      out_dst_offset_r <= s2_dst_prod_r + OFS_W'(s2_dst_add_r);
      out_row_end_r    <= s2_row_end_r;
      out_frame_end_r  <= s2_frame_end_r;
    end
  end

  assign out_src_offset = out_src_offset_r;
  assign out_dst_offset = out_dst_offset_r;
  assign out_row_end    = out_row_end_r;
  assign out_frame_end  = out_frame_end_r;

  a_col_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> ({1'b0, col_rem_r} < dw))
    else $error("column remainder not below destination width");
  a_row_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> ({1'b0, row_rem_r} < dh))
    else $error("row remainder not below destination height");

endmodule

FILE: hdl/nnsa_ctrl.sv
// Controller: ratio recompute sequencing and the valid bits of the offset pipeline.
module nnsa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output nnsa_pkg::dp_cmd_t    cmd,
  input  nnsa_pkg::dp_status_t status
);
  import nnsa_pkg::*;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV_START,
    ST_DIV_WAIT
  } state_t;

  state_t   state_r, state_nxt;
  div_sel_t sel_r, sel_nxt, sel_inc;
  logic     dirty_r, dirty_nxt;
  logic     s1_v_r, s2_v_r, out_v_r;
  logic     move;
  logic     accept;

  assign move     = !out_v_r || out_ready;
  assign in_ready = (state_r == ST_RUN) && !dirty_r && move;
  assign accept   = in_valid && in_ready;

  always_comb begin
    unique case (sel_r)
      DIV_COL_RATIO: sel_inc = DIV_ROW_RATIO;
      DIV_ROW_RATIO: sel_inc = DIV_COL_POS;
      DIV_COL_POS:   sel_inc = DIV_ROW_POS;
      DIV_ROW_POS:   sel_inc = DIV_COL_RATIO;
      default:       sel_inc = DIV_COL_RATIO;
    endcase
  end

  // Any register write invalidates the ratios and the scan position's quotients.
  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    dirty_nxt = cfg_we || (dirty_r && (state_r != ST_RUN));
    unique case (state_r)
      ST_RUN: begin
        if (dirty_r) begin
          state_nxt = ST_DIV_START;
          sel_nxt   = DIV_COL_RATIO;
        end
      end
      ST_DIV_START: begin
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status.div_done) begin
          if (sel_r == DIV_ROW_POS) begin
            state_nxt = ST_RUN;
          end else begin
            state_nxt = ST_DIV_START;
            sel_nxt   = sel_inc;
          end
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
      sel_r   <= DIV_COL_RATIO;
      dirty_r <= 1'b1;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      dirty_r <= dirty_nxt;
      if (move) begin
        s1_v_r  <= accept;
        s2_v_r  <= s1_v_r;
        out_v_r <= s2_v_r;
      end
    end
  end

  assign out_valid     = out_v_r;
  assign cmd.step      = accept;
  assign cmd.move      = move;
  assign cmd.div_start = (state_r == ST_DIV_START);
  assign cmd.div_load  = (state_r == ST_DIV_WAIT) && status.div_done;
  assign cmd.div_sel   = sel_r;

endmodule

FILE: hdl/nearest_neighbor_scale_addr_gen.sv
// Nearest-neighbour scaling address generator, top level.
// Each input transfer yields one source and one destination pixel offset for a
// nearest-neighbour scaled copy, walking the destination rectangle in raster order,
// with flags for the last pixel of a row and of the frame; restart begins again at
// the first pixel. Items are taken one per cycle when in_ready is high; each result
// passes the stage-one, stage-two and output registers, the output register holding
// it until taken while the pipeline stalls as a whole. Source coordinates are stepped
// by adding the quotient and remainder of the size ratios, so no division happens per
// pixel. Those ratios, and the quotients of the current scan position, come from a
// serial divider that produces one bit per cycle: after reset and after any register
// write in_ready stays low while four divisions run. Register writes are always taken
// (cfg_ready is tied high).
module nearest_neighbor_scale_addr_gen (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [nnsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nnsa_pkg::DIM_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_restart,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [nnsa_pkg::OFS_W-1:0]     out_src_offset,
  output logic [nnsa_pkg::OFS_W-1:0]     out_dst_offset,
  output logic                           out_row_end,
  output logic                           out_frame_end
);
  import nnsa_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  nnsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  nnsa_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_reg_t'(cfg_index)),
    .cfg_data       (cfg_data),
    .in_restart     (in_restart),
    .cmd            (cmd),
    .status         (status),
    .out_src_offset (out_src_offset),
    .out_dst_offset (out_dst_offset),
    .out_row_end    (out_row_end),
    .out_frame_end  (out_frame_end)
  );

endmodule
